### rtl/bss_pkg.sv
// Shared types, constants and bit helpers for the bitmap set-bit search block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package bss_pkg;

  // Fixed field widths of the channels and the configuration register, default word count and set size reset value.
  localparam int WORD_BITS     = 64;
  localparam int BIT_IDX_W     = 6;
  localparam int IDX_W         = 4;
  localparam int POS_W         = 10;
  localparam int RES_W         = 11;
  localparam int CFG_W         = 11;
  localparam int POP_W         = 7;
  localparam int NUM_WORDS_DEF = 16;
  localparam int SET_BITS_RST  = 1024;

  // Request type codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Result value for "no such bit".
  localparam logic [RES_W-1:0] RES_NONE = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;   // an input item transfers this cycle
    logic take_write;  // that item is a word write
    logic clr_we;      // clearing pass writes zero at the sequencer address
    logic rd_en;       // scan reads the word at the sequencer address
    logic out_load;    // final result moves into the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_empty;  // no scanned word left in the read or mask stages
  } dp_sts_t;

  // Mask of the bits of a word that lie below a bound.
  // above: the bound lies in a later word; same: it lies in this word at low6.
  function automatic logic [WORD_BITS-1:0] low_mask(input logic above, input logic same,
                                                     input logic [BIT_IDX_W-1:0] low6);
    logic [WORD_BITS-1:0] m;
    m = '0;
    if (above) begin
      m = '1;
    end else if (same) begin
      m = (WORD_BITS'(1) << low6) - WORD_BITS'(1);
    end
    return m;
  endfunction

  // Index of the lowest set bit (0 when the word is zero).
  function automatic logic [BIT_IDX_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

  // Index of the highest set bit (0 when the word is zero).
  function automatic logic [BIT_IDX_W-1:0] highest_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

  // Number of set bits in a word.
  function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
    logic [POP_W-1:0] c;
    c = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      c = c + POP_W'(v[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/bss_in_if.sv
// Request channel: valid/ready handshake with a write or query item.
// Depends on bss_pkg for field widths.
`default_nettype none

interface bss_in_if;
  import bss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [IDX_W-1:0]     word_index;
  logic [WORD_BITS-1:0] word_value;
  logic [POS_W-1:0]     bit_position;

  modport source (output valid, req_type, word_index, word_value, bit_position,
                  input ready);
  modport sink   (input valid, req_type, word_index, word_value, bit_position,
                  output ready);
endinterface

`default_nettype wire

### rtl/bss_out_if.sv
// Result channel: valid/ready handshake with the three search results.
// Depends on bss_pkg for field widths.
`default_nettype none

interface bss_out_if;
  import bss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] next_set;
  logic signed [RES_W-1:0] prev_set;
  logic        [RES_W-1:0] count_after;

  modport source (output valid, next_set, prev_set, count_after, input ready);
  modport sink   (input valid, next_set, prev_set, count_after, output ready);
endinterface

`default_nettype wire

### rtl/bitmap_set_bit_search.sv
// Bitmap set-bit search.
// Holds NUM_WORDS bitmap words of 64 bits. Items arrive on in_ch (valid/ready).
// A write item (req_type 0) replaces word word_index; an index past the
// bitmap is ignored. A query item (req_type 1) returns, for bit_position,
// the lowest member at or after it, the highest member before it (-1 when
// none) and the member count at or after it. Members are set bits below
// set_bits, which the user writes through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce it. Every item gives one result
// on out_ch; a write gives -1, -1, 0. A write passes to S_DONE, where its
// result is loaded into the output register once that is free, and then to
// S_IDLE, where the next item is taken. A query reads one word per cycle from
// the single read port in S_SCAN, waits in S_DRAIN for the read and mask
// stages to empty and is loaded in S_DONE. No new item is taken until then.
// The next item is taken while a result waits in the output register; a
// stalled receiver holds the block only once a second result is finished.
// After reset the memory is cleared one word per cycle, with in_ch not ready;
// set_bits resets to 1024.
// Depends on bss_pkg, bss_in_if, bss_out_if, bss_ctrl and bss_dpath.
`default_nettype none

module bitmap_set_bit_search #(
  parameter int NUM_WORDS = bss_pkg::NUM_WORDS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  bss_in_if.sink                         in_ch,
  bss_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [bss_pkg::CFG_W-1:0] cfg_wdata
);
  import bss_pkg::*;

  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  ctl_cmd_t         cmd;
  dp_sts_t          sts;
  logic [AW-1:0]    addr;
  logic [RES_W-1:0] next_set;
  logic [RES_W-1:0] prev_set;

  bss_ctrl #(
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .sts         (sts),
    .cmd         (cmd),
    .addr        (addr)
  );

  bss_dpath #(
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .addr            (addr),
    .sts             (sts),
    .in_word_index   (in_ch.word_index),
    .in_word_value   (in_ch.word_value),
    .in_bit_position (in_ch.bit_position),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_next_set    (next_set),
    .out_prev_set    (prev_set),
    .out_count_after (out_ch.count_after)
  );

  assign out_ch.next_set = $signed(next_set);
  assign out_ch.prev_set = $signed(prev_set);

endmodule

`default_nettype wire

### rtl/bss_ctrl.sv
// Controller: clearing pass after reset, item intake, word scan sequencing
// and output register handoff. Depends on bss_pkg.
`default_nettype none

module bss_ctrl #(
  parameter int NUM_WORDS = bss_pkg::NUM_WORDS_DEF,
  parameter int AW        = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_req_type,
  output logic                   in_ready,
  input  wire logic              out_ready,
  output logic                   out_valid,
  input  wire bss_pkg::dp_sts_t  sts,
  output bss_pkg::ctl_cmd_t      cmd,
  output logic [AW-1:0]          addr
);
  import bss_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(NUM_WORDS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Next state, sequencer count and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          cnt_nxt       = '0;
          if (in_req_type == REQ_QUERY) begin
            state_nxt = S_SCAN;
          end else begin
            cmd.take_write = 1'b1;
            state_nxt      = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  // The output register fills on a load and empties on a transfer.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign addr      = cnt_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### rtl/bss_dpath.sv
// Datapath: bitmap word memory, set size register, per-word mask stage,
// result accumulators and output register. Depends on bss_pkg.
`default_nettype none

module bss_dpath #(
  parameter int NUM_WORDS = bss_pkg::NUM_WORDS_DEF,
  parameter int AW        = 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bss_pkg::ctl_cmd_t               cmd,
  input  wire logic [AW-1:0]                   addr,
  output bss_pkg::dp_sts_t                     sts,
  input  wire logic [bss_pkg::IDX_W-1:0]       in_word_index,
  input  wire logic [bss_pkg::WORD_BITS-1:0]   in_word_value,
  input  wire logic [bss_pkg::POS_W-1:0]       in_bit_position,
  input  wire logic                            cfg_we,
  input  wire logic [bss_pkg::CFG_W-1:0]       cfg_wdata,
  output logic [bss_pkg::RES_W-1:0]            out_next_set,
  output logic [bss_pkg::RES_W-1:0]            out_prev_set,
  output logic [bss_pkg::RES_W-1:0]            out_count_after
);
  import bss_pkg::*;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];

  logic [CFG_W-1:0]     set_bits_r;
  logic [POS_W-1:0]     pos_r;

  logic                 wr_in_range;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  logic [WORD_BITS-1:0] rd_data_r;
  logic [AW-1:0]        rd_w_r;
  logic                 rd_vld_r;

  logic [WORD_BITS-1:0] members;
  logic [WORD_BITS-1:0] pos_mask;
  logic [WORD_BITS-1:0] after_r, after_nxt;
  logic [WORD_BITS-1:0] before_r, before_nxt;
  logic [AW-1:0]        s1_w_r;
  logic                 s1_vld_r;

  logic [RES_W-1:0]     base;
  logic [RES_W-1:0]     next_r, prev_r, count_r;
  logic                 found_r;
  logic [RES_W-1:0]     next_out_r, prev_out_r, count_out_r;

  // Set size register; its upper bits select the word and its low bits the bit within it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= CFG_W'(SET_BITS_RST);
    end else if (cfg_we) begin
      set_bits_r <= cfg_wdata;
    end
  end

  // Memory write port: the clearing pass or a word write inside the bitmap.
  assign wr_in_range = 32'(in_word_index) < NUM_WORDS;
  assign mem_we      = cmd.clr_we || (cmd.take_write && wr_in_range);
  assign mem_wa      = cmd.clr_we ? addr : AW'(in_word_index);
  assign mem_wd      = cmd.clr_we ? '0 : in_word_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // Registered read of the scanned word.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[addr];
      rd_w_r    <= addr;
    end
  end

  // Mask stage: keep set members and split them around the query position.
  always_comb begin
    members = rd_data_r & low_mask(32'(rd_w_r) < 32'(set_bits_r[CFG_W-1:BIT_IDX_W]),
                                   32'(rd_w_r) == 32'(set_bits_r[CFG_W-1:BIT_IDX_W]),
                                   set_bits_r[BIT_IDX_W-1:0]);
    pos_mask = low_mask(32'(rd_w_r) < 32'(pos_r[POS_W-1:BIT_IDX_W]),
                        32'(rd_w_r) == 32'(pos_r[POS_W-1:BIT_IDX_W]),
                        pos_r[BIT_IDX_W-1:0]);
    after_nxt  = members & ~pos_mask;
    before_nxt = members & pos_mask;
  end

  always_ff @(posedge clk) begin
    after_r  <= after_nxt;
    before_r <= before_nxt;
    s1_w_r   <= rd_w_r;
  end

  // Stage valid flags follow the scanned words through the pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      s1_vld_r <= rd_vld_r;
    end
  end

  assign sts.pipe_empty = !rd_vld_r && !s1_vld_r;

  // Accumulators: first nonzero word gives next, last nonzero word gives prev.
  assign base = RES_W'({s1_w_r, {BIT_IDX_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      pos_r   <= in_bit_position;
      next_r  <= RES_NONE;
      prev_r  <= RES_NONE;
      count_r <= '0;
      found_r <= 1'b0;
    end else if (s1_vld_r) begin
      count_r <= count_r + RES_W'(popcount(after_r));
      if (!found_r && (after_r != '0)) begin
        next_r  <= base + RES_W'(lowest_bit(after_r));
        found_r <= 1'b1;
      end
      if (before_r != '0) begin
        prev_r <= base + RES_W'(highest_bit(before_r));
      end
    end
  end

  // Output register holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      next_out_r  <= next_r;
      prev_out_r  <= prev_r;
      count_out_r <= count_r;
    end
  end

  assign out_next_set    = next_out_r;
  assign out_prev_set    = prev_out_r;
  assign out_count_after = count_out_r;

endmodule

`default_nettype wire
